// File: hdl/fia_pkg.sv
// ----------------------------------------------------------------------------
// fia_pkg
// Shared types and constants of the FIFO index allocator.
// ----------------------------------------------------------------------------
package fia_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;

    typedef enum logic [0:0] {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    typedef struct packed {
        t_func             func;
        logic [SLOT_W-1:0] release_index;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        t_status           status;
        logic [CNT_W-1:0]  free_count;
    } t_out_word;

endpackage

// File: hdl/fifo_index_allocator_core.sv
// ----------------------------------------------------------------------------
// fifo_index_allocator_core
// Hands out slot indices from a pool in first-in first-out order.
// ----------------------------------------------------------------------------
// Each word has a read step, which reads the free queue and the in-use map
// (both single-port synchronous memories), and an update step, which
// updates them and loads the result register. A result waiting on a
// stalled output holds the block in its update step. Writing the capacity
// register restarts the pool at once; entries not yet written since then are
// tracked with push and pop fill counts, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_index_allocator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fia_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fia_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [fia_pkg::CNT_W-1:0] i_cfg_data
);
    import fia_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    logic [SLOT_W-1:0] r_queue_mem [MAX_SLOTS];
    logic              r_map_mem   [MAX_SLOTS];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_pushed, n_pushed;
    logic [CNT_W-1:0]  r_popped, n_popped;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;
    t_func             r_func;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_q_rdata;
    logic              r_map_rdata;

    logic              in_acc, cfg_acc, exec_go;
    logic              q_written, map_bit;
    logic [SLOT_W-1:0] pop_slot, q_dist;
    logic [CNT_W-1:0]  cap_clamped;
    logic              q_we, map_we, map_wdata;
    logic [SLOT_W-1:0] q_waddr, map_waddr;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign q_dist    = r_head - r_cap[SLOT_W-1:0];
    assign q_written = ({1'b0, q_dist} < r_pushed);
    assign pop_slot  = q_written ? r_q_rdata : r_head;
    assign map_bit   = ({1'b0, r_idx} < r_popped) ? r_map_rdata : 1'b0;

    always_comb begin
        if (i_cfg_data == '0) begin
            cap_clamped = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(MAX_SLOTS)) begin
            cap_clamped = CNT_W'(MAX_SLOTS);
        end else begin
            cap_clamped = i_cfg_data;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pushed    = r_pushed;
        n_popped    = r_popped;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        q_we        = 1'b0;
        q_waddr     = r_tail;
        map_we      = 1'b0;
        map_waddr   = r_idx;
        map_wdata   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_cap    = cap_clamped;
                    n_head   = '0;
                    n_tail   = cap_clamped[SLOT_W-1:0];
                    n_count  = cap_clamped;
                    n_pushed = '0;
                    n_popped = '0;
                end
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state                = S_IDLE;
                    n_out_valid            = 1'b1;
                    n_out_word.slot_index  = '0;
                    n_out_word.status      = ST_OK;
                    if (r_func == FUNC_ALLOC) begin
                        if (r_count == '0) begin
                            n_out_word.status = ST_EMPTY;
                        end else begin
                            n_out_word.slot_index = pop_slot;
                            map_we    = 1'b1;
                            map_waddr = pop_slot;
                            map_wdata = 1'b1;
                            n_head    = r_head + 1'b1;
                            n_count   = r_count - 1'b1;
                            if (r_popped != CNT_W'(MAX_SLOTS)) begin
                                n_popped = r_popped + 1'b1;
                            end
                        end
                    end else begin
                        if (({1'b0, r_idx} >= r_cap) || !map_bit ||
                                (r_count >= CNT_W'(MAX_SLOTS))) begin
                            n_out_word.status = ST_NOT_USED;
                        end else begin
                            map_we  = 1'b1;
                            q_we    = 1'b1;
                            n_tail  = r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_pushed != CNT_W'(MAX_SLOTS)) begin
                                n_pushed = r_pushed + 1'b1;
                            end
                        end
                    end
                    n_out_word.free_count = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CNT_W'(MAX_SLOTS);
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= CNT_W'(MAX_SLOTS);
            r_pushed    <= '0;
            r_popped    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_pushed    <= n_pushed;
            r_popped    <= n_popped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        if (in_acc) begin
            r_func <= i_in_word.func;
            r_idx  <= i_in_word.release_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue_mem[q_waddr] <= r_idx;
        end
        if (in_acc) begin
            r_q_rdata <= r_queue_mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        if (in_acc) begin
            r_map_rdata <= r_map_mem[i_in_word.release_index];
        end
    end

endmodule

// File: sim/fia_allocation_checker.sv
// ----------------------------------------------------------------------------
// fia_allocation_checker
// Watches the request, result and capacity channels of the FIFO index
// allocator, keeps its own copy of the free queue and the in-use map,
// predicts the result word of every accepted request and compares each
// accepted result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module fia_allocation_checker
    import fia_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_word           i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_word          i_out_word,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 100;

    logic [SLOT_W-1:0] free_ring [MAX_SLOTS];
    logic              slot_taken [MAX_SLOTS];
    logic [SLOT_W-1:0] ring_head;
    logic [SLOT_W-1:0] ring_tail;
    logic [CNT_W-1:0]  free_slots;
    logic [CNT_W-1:0]  pool_size;
    t_out_word         awaited_results [$];
    t_out_word         oldest_result;
    int                awaited_count = 0;
    int                fail_count = 0;

    assign o_pending    = awaited_count;
    assign o_fail_count = fail_count;

    function automatic void refill_pool(input logic [CNT_W-1:0] data);
        if (data == '0) begin
            pool_size = CNT_W'(1);
        end else if (data > CNT_W'(MAX_SLOTS)) begin
            pool_size = CNT_W'(MAX_SLOTS);
        end else begin
            pool_size = data;
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            free_ring[i]  = SLOT_W'(i);
            slot_taken[i] = 1'b0;
        end
        ring_head  = '0;
        ring_tail  = SLOT_W'(pool_size);
        free_slots = pool_size;
    endfunction

    function automatic t_out_word apply_request(input t_in_word req);
        t_out_word res;
        res.slot_index = '0;
        res.status     = ST_OK;
        if (req.func == FUNC_ALLOC) begin
            if (free_slots == '0) begin
                res.status = ST_EMPTY;
            end else begin
                res.slot_index                = free_ring[ring_head];
                slot_taken[free_ring[ring_head]] = 1'b1;
                ring_head                     = ring_head + 1'b1;
                free_slots                    = free_slots - 1'b1;
            end
        end else if (CNT_W'(req.release_index) >= pool_size
                     || !slot_taken[req.release_index]
                     || free_slots >= CNT_W'(MAX_SLOTS)) begin
            res.status = ST_NOT_USED;
        end else begin
            slot_taken[req.release_index] = 1'b0;
            free_ring[ring_tail]          = req.release_index;
            ring_tail                     = ring_tail + 1'b1;
            free_slots                    = free_slots + 1'b1;
        end
        res.free_count = free_slots;
        return res;
    endfunction

    function automatic void note_mismatch(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            refill_pool(CNT_W'(MAX_SLOTS));
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t ns: result word expected none, actual %h",
                                 $time, i_out_word);
                    end
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (i_out_word.slot_index !== oldest_result.slot_index) begin
                        note_mismatch("slot_index", int'(oldest_result.slot_index),
                                      int'(i_out_word.slot_index));
                    end
                    if (i_out_word.status !== oldest_result.status) begin
                        note_mismatch("status", int'(oldest_result.status),
                                      int'(i_out_word.status));
                    end
                    if (i_out_word.free_count !== oldest_result.free_count) begin
                        note_mismatch("free_count", int'(oldest_result.free_count),
                                      int'(i_out_word.free_count));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                refill_pool(i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_request(i_in_word));
            end
        end
        awaited_count = awaited_results.size();
    end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the FIFO index allocator with a short directed sequence and then
// with random phases of allocate and release words, each phase starting
// from a fresh capacity. Both channels idle at random but in phase 1; a checker
// beside the block predicts every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import fia_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 118;
    localparam int IDLE_PCT       = 14;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_word        out_word;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    int               pending;
    int               fail_count;
    int               idle_cycles = 0;
    bit               calm = 1'b0;

    always #5ns clk = ~clk;

    fifo_index_allocator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    fia_allocation_checker u_alloc_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_request(input t_func func, input logic [SLOT_W-1:0] index);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{func: func, release_index: index};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CNT_W-1:0] cap_word;
        int unsigned      pool;
        int unsigned      allocs;
        int unsigned      alloc_pct;
        int unsigned      pick;
        int unsigned      hi;
        logic [SLOT_W-1:0] index;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        issue_request(FUNC_ALLOC, '0);
        issue_request(FUNC_RELEASE, '0);
        issue_request(FUNC_RELEASE, '0);
        issue_request(FUNC_RELEASE, '1);
        issue_request(FUNC_ALLOC, 10'h2AA);

        write_capacity(CNT_W'(2));
        issue_request(FUNC_ALLOC, 10'h155);
        issue_request(FUNC_ALLOC, '0);
        issue_request(FUNC_ALLOC, '0);
        issue_request(FUNC_RELEASE, 10'd2);
        issue_request(FUNC_RELEASE, 10'd1);
        issue_request(FUNC_RELEASE, 10'd1);
        issue_request(FUNC_ALLOC, '0);
        issue_request(FUNC_RELEASE, 10'd0);
        issue_request(FUNC_RELEASE, 10'd1);

        write_capacity('0);
        issue_request(FUNC_ALLOC, '0);
        issue_request(FUNC_ALLOC, '0);
        issue_request(FUNC_RELEASE, 10'd0);
        issue_request(FUNC_RELEASE, 10'd1);

        write_capacity('1);
        issue_request(FUNC_RELEASE, '1);
        issue_request(FUNC_ALLOC, '0);

        write_capacity(CNT_W'(1025));
        issue_request(FUNC_ALLOC, '1);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: cap_word = CNT_W'(1024);
                1: cap_word = CNT_W'(1000);
                2: cap_word = CNT_W'(3);
                3: cap_word = CNT_W'(16);
                4: cap_word = CNT_W'(1);
                5: cap_word = CNT_W'($urandom_range(4, 300));
                6: cap_word = CNT_W'(2);
                default: cap_word = CNT_W'($urandom_range(0, 2047));
            endcase
            write_capacity(cap_word);
            pool      = (cap_word == '0) ? 1 : ((cap_word > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS
                                                                              : cap_word);
            allocs    = 0;
            alloc_pct = $urandom_range(35, 65);
            calm      = (p == 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct) begin
                    allocs++;
                    issue_request(FUNC_ALLOC, SLOT_W'($urandom));
                end else begin
                    if (pick < 88) begin
                        hi    = (allocs < pool) ? allocs : pool;
                        index = (hi == 0) ? '0 : SLOT_W'($urandom_range(0, hi - 1));
                    end else if (pick < 95 || pool >= MAX_SLOTS) begin
                        index = SLOT_W'($urandom);
                    end else begin
                        index = SLOT_W'($urandom_range(pool, MAX_SLOTS - 1));
                    end
                    issue_request(FUNC_RELEASE, index);
                end
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
